FILE: sv/avpq_pkg.sv
// Package for the absolute-value priority queue.
// Holds sizes, the ordering key function and the structs passed between cells.
// No dependencies.
package avpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int KEY_W    = VAL_W + 1;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_op;

    // What a cell shows its neighbours: its entry, and whether the value being
    // inserted sorts ahead of that entry (always so for an empty cell).
    typedef struct packed {
        logic             ahead;
        logic [VAL_W-1:0] value;
    } t_link;

    // Magnitude first, then sign: a negative value sorts ahead of a positive
    // one of the same magnitude. The most negative value has the largest key.
    function automatic logic [KEY_W-1:0] order_key(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] mag;
        mag = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
        return {mag, ~v[VAL_W-1]};
    endfunction

endpackage

FILE: sv/absolute_value_priority_queue.sv
// A result strobes in the cycle after the transfer that causes it.
// Throughput: one item per cycle; busy is never raised, as each cell of the
// sorted chain computes its new entry combinationally and registers it directly.
// Reset (synchronous, active low) empties the queue and clears the strobe;
// results cannot be stalled, each shows for exactly one cycle.
module absolute_value_priority_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic signed [31:0]         i_value,
    output logic                       o_strobe,
    output logic signed [31:0]         o_removed_value,
    output logic                       o_was_empty,
    output logic                       o_dropped
);

    // The queue is kept fully sorted in a chain of cells, smallest key at
    // cell zero. Only the entry count and the strobe are reset: a cell at or beyond the count
    // is empty whatever it holds, so no per-cell valid flag is needed.

    logic [avpq_pkg::CNT_W-1:0] r_count;
    logic [avpq_pkg::CNT_W-1:0] n_count;
    logic                       r_strobe;
    logic [31:0]                r_removed_value;
    logic                       r_was_empty;
    logic                       r_dropped;

    logic                       w_accept;
    logic                       w_remove;
    logic                       w_empty;
    logic                       w_full;
    avpq_pkg::t_op              w_op;
    avpq_pkg::t_link            w_link [avpq_pkg::CAPACITY];
    avpq_pkg::t_link            w_head_prev;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_remove = (i_value == 32'sd0);
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == avpq_pkg::CNT_W'(avpq_pkg::CAPACITY));

    // The value to insert and the operation are broadcast to every cell.
    assign w_op.ins   = w_accept && !w_remove && !w_full;
    assign w_op.rem   = w_accept && w_remove && !w_empty;
    assign w_op.value = i_value;
    assign w_op.key   = avpq_pkg::order_key(i_value);
    assign w_op.count = r_count;

    // Nothing sits ahead of the head cell, so an insert never comes from there.
    assign w_head_prev.ahead = 1'b0;
    assign w_head_prev.value = '0;

    for (genvar g = 0; g < avpq_pkg::CAPACITY; g++) begin : g_cell
        avpq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (avpq_pkg::IDX_W'(g)),
            .i_op    (w_op),
            .i_prev  ((g == 0) ? w_head_prev : w_link[(g == 0) ? 0 : g - 1]),
            .i_next  (w_link[(g == avpq_pkg::CAPACITY - 1) ? g : g + 1]),
            .o_link  (w_link[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_op.ins) begin
            n_count = r_count + avpq_pkg::CNT_W'(1);
        end else if (w_op.rem) begin
            n_count = r_count - avpq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= w_accept && (w_remove || w_full);
        end
    end

    // Result payload: the head entry on a removal, zero with a flag when the
    // queue was empty or the insert found it full.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed_value <= (w_remove && !w_empty) ? w_link[0].value : 32'd0;
            r_was_empty     <= w_remove && w_empty;
            r_dropped       <= !w_remove && w_full;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_removed_value = r_removed_value;
    assign o_was_empty     = r_was_empty;
    assign o_dropped       = r_dropped;

endmodule

FILE: sv/avpq_cell.sv
// One cell of the sorted chain: holds a single entry of the queue.
// Depends on avpq_pkg for the ordering key and the link structs.
module avpq_cell (
    input  logic                       i_clk,
    input  logic [avpq_pkg::IDX_W-1:0] i_index,
    input  avpq_pkg::t_op              i_op,
    input  avpq_pkg::t_link            i_prev,
    input  avpq_pkg::t_link            i_next,
    output avpq_pkg::t_link            o_link
);

    logic [avpq_pkg::VAL_W-1:0] r_value;
    logic [avpq_pkg::VAL_W-1:0] n_value;
    logic                       w_valid;

    assign w_valid      = {1'b0, i_index} < i_op.count;
    assign o_link.value = r_value;
    assign o_link.ahead = !w_valid || (i_op.key < avpq_pkg::order_key(r_value));

    // On insert, the cells from the insertion point onward shift one place
    // towards the tail; on removal, the whole chain shifts towards the head.
    always_comb begin
        n_value = r_value;
        if (i_op.ins) begin
            if (o_link.ahead) begin
                n_value = i_prev.ahead ? i_prev.value : i_op.value;
            end
        end else if (i_op.rem) begin
            n_value = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: sv/avpq_checker.sv
// Port-level checks for the absolute-value priority queue.
// Bound to absolute_value_priority_queue; uses only its ports.
module avpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic signed [31:0] i_value,
    input logic               o_strobe,
    input logic signed [31:0] o_removed_value,
    input logic               o_was_empty,
    input logic               o_dropped
);

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_was_empty && o_dropped))
        else $error("empty and dropped flags raised together");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_was_empty || o_dropped)) |-> (o_removed_value == 32'sd0))
        else $error("flagged result carries a nonzero value");

    a_remove_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_value == 32'sd0)) |=> o_strobe)
        else $error("removal transfer gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(i_start && !o_busy))
        else $error("result strobe without a preceding transfer");

endmodule

bind absolute_value_priority_queue avpq_checker u_avpq_checker (.*);

FILE: tb/avpq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the absolute-value priority queue testbench.
// Holds its own copy of the stored entries and the queue of awaited results.
// Depends on avpq_pkg for the capacity and the value width.
package avpq_scoreboard_pkg;

    typedef struct packed {
        logic [avpq_pkg::VAL_W-1:0] removed_value;
        logic                       was_empty;
        logic                       dropped;
    } t_queue_result;

    class t_queue_scoreboard;

        logic [avpq_pkg::VAL_W-1:0] held [avpq_pkg::CAPACITY];
        int unsigned                held_count;
        t_queue_result              awaited [$];
        int unsigned                mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        // Magnitude above, sign below, so that a negative entry wins a tie.
        function automatic logic [avpq_pkg::VAL_W:0] rank(input logic [avpq_pkg::VAL_W-1:0] v);
            logic [avpq_pkg::VAL_W-1:0] mag;
            mag = v[avpq_pkg::VAL_W-1] ? (~v + 1'b1) : v;
            return {mag, ~v[avpq_pkg::VAL_W-1]};
        endfunction

        // Entries are kept unordered; a removal scans for the lowest rank. Equal ranks
        // mean equal values, so the pick among them does not matter.
        function void note_transfer(input logic [avpq_pkg::VAL_W-1:0] v);
            t_queue_result r;
            int unsigned   best;
            r = '0;
            if (v == '0) begin
                if (held_count == 0) begin
                    r.was_empty = 1'b1;
                end else begin
                    best = 0;
                    for (int unsigned i = 1; i < held_count; i++) begin
                        if (rank(held[i]) < rank(held[best])) begin
                            best = i;
                        end
                    end
                    r.removed_value = held[best];
                    held[best] = held[held_count - 1];
                    held_count--;
                end
                awaited.push_back(r);
            end else if (held_count >= avpq_pkg::CAPACITY) begin
                r.dropped = 1'b1;
                awaited.push_back(r);
            end else begin
                held[held_count] = v;
                held_count++;
            end
        endfunction

        task report_mismatch(input string what);
            if (mismatches < 200) begin
                $display("MISMATCH: %s", what);
            end
            mismatches++;
        endtask

        task check_result(input logic [avpq_pkg::VAL_W-1:0] removed_value,
                          input logic was_empty, input logic dropped);
            t_queue_result want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %h/%b/%b with nothing awaited",
                                          removed_value, was_empty, dropped));
            end else begin
                want = awaited.pop_front();
                if (removed_value !== want.removed_value) begin
                    report_mismatch($sformatf("removed_value %h, wanted %h",
                                              removed_value, want.removed_value));
                end
                if (was_empty !== want.was_empty) begin
                    report_mismatch($sformatf("was_empty %b, wanted %b",
                                              was_empty, want.was_empty));
                end
                if (dropped !== want.dropped) begin
                    report_mismatch($sformatf("dropped %b, wanted %b",
                                              dropped, want.dropped));
                end
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction

        function int stored();
            return held_count;
        endfunction

    endclass

endpackage

FILE: tb/tb_absolute_value_priority_queue.sv
`timescale 1ns / 100ps
// Top level of the testbench for absolute_value_priority_queue.
// Drives values in several idling phases and checks each strobed result.
// Depends on avpq_pkg and avpq_scoreboard_pkg.
module tb_absolute_value_priority_queue;

    // The block keeps up with one item per cycle, so a run of about eleven hundred
    // items with the idle cycles of the slower phases ends well within the limit.
    localparam int LIMIT_CYCLES = 200000;
    localparam int CAP          = avpq_pkg::CAPACITY;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_start = 1'b0;
    logic signed [avpq_pkg::VAL_W-1:0] i_value = '0;
    logic                            o_busy;
    logic                            o_strobe;
    logic signed [avpq_pkg::VAL_W-1:0] o_removed_value;
    logic                            o_was_empty;
    logic                            o_dropped;

    avpq_scoreboard_pkg::t_queue_scoreboard sb = new();
    int unsigned                            cycle_count = 0;

    always #1 i_clk = ~i_clk;

    absolute_value_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_was_empty     (o_was_empty),
        .o_dropped       (o_dropped)
    );

    // Everything is sampled at the rising edge. The strobed result belongs to an
    // earlier transfer whose expectation is already queued, so it is checked before
    // the transfer taken at this edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_removed_value, o_was_empty, o_dropped);
            end
            if (i_start && !o_busy) begin
                sb.note_transfer(i_value);
            end
        end
    end

    // Watchdog: a hung block or a result that never comes ends the run here.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_absolute_value_priority_queue NOT OK");
        $finish;
    end

    // Presents one value at the falling edge and returns at the rising edge that
    // completes the transfer. Busy only moves on a rising edge, so its value at the
    // falling edge is the one seen at the next rising edge. Start is left high, so a
    // following call keeps it high without lowering it in between.
    task automatic send_value(input logic signed [avpq_pkg::VAL_W-1:0] v);
        logic busy_seen;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_value <= v;
        busy_seen = 1'b1;
        while (busy_seen) begin
            busy_seen = o_busy;
            @(posedge i_clk);
            if (busy_seen) begin
                @(negedge i_clk);
            end
        end
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Holds the sender off until every awaited result has come, then waits on further
    // rising edges, as an insert leaves nothing to wait on.
    task automatic wait_settled();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // A zero requests a removal. Inserted values mix the full range, small
    // magnitudes that often tie in magnitude or repeat, and the extremes.
    function automatic logic signed [avpq_pkg::VAL_W-1:0] pick_value(input int insert_pct);
        logic [avpq_pkg::VAL_W-1:0] v;
        if ($urandom_range(99) >= insert_pct) begin
            return '0;
        end
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: begin
                v = $urandom_range(1, 12);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
            7: begin
                case ($urandom_range(4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h8000_0001;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
        endcase
        if (v == '0) begin
            v = 32'h0000_0001;
        end
        return v;
    endfunction

    // Sends random items; with until_full set it goes on until the store is full.
    // In an idling phase each cycle ahead of an item is idle with the given chance,
    // except that the first eight items of every forty run back to back.
    task automatic run_items(input int count, input int insert_pct, input int idle_pct,
                             input bit until_full);
        int n;
        n = 0;
        while (until_full ? (sb.stored() < CAP) : (n < count)) begin
            if ((n % 40) >= 8) begin
                while ($urandom_range(99) < idle_pct) begin
                    pause_sender(1);
                end
            end
            send_value(pick_value(insert_pct));
            n++;
        end
    endtask

    logic signed [avpq_pkg::VAL_W-1:0] directed [20];

    initial begin
        // Removal from an empty store, then ties of magnitude, the largest magnitudes
        // and the most negative value, then removals down to empty and one more.
        directed = '{32'sd0, 32'sd5, -32'sd5, 32'sd3, -32'sd3,
                     32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd2147483647, 32'sd1, -32'sd1,
                     32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                     32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            send_value(directed[k]);
        end
        wait_settled();

        // No idling, then a mostly idle sender.
        run_items(40, 80, 0, 1'b0);
        wait_settled();
        run_items(40, 80, 85, 1'b0);
        wait_settled();

        // Fill the store, then work around the full mark so that inserts are dropped.
        run_items(0, 99, 30, 1'b1);
        run_items(20, 50, 30, 1'b0);
        wait_settled();
        run_items(15, 45, 85, 1'b0);
        run_items(10, 0, 0, 1'b0);
        wait_settled();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_absolute_value_priority_queue OK");
        end else begin
            $display("tb_absolute_value_priority_queue NOT OK");
        end
        $finish;
    end

endmodule
